// ===== rtl/mtpt_pkg.sv =====
// Package with shared types and constants of the multi-turn encoder position tracker.
`timescale 1ns / 1ps
package mtpt_pkg;

  localparam int ACC_WIDTH_DEF   = 32;
  localparam int REV_W           = 16;
  localparam int SINGLE_W        = 24;
  localparam int POS_W           = 56;
  localparam int PPR_W           = 25;
  localparam int BASE_W          = 41;
  localparam int CFG_DATA_W      = 41;
  localparam int CFG_IDX_W       = 3;
  localparam int WORD_W          = 64;
  localparam int OVERSPEED_LIMIT = 40000;
  localparam int WARMUP_DONE     = 3;
  localparam int SEED_STEP       = 2;

  localparam logic [REV_W-1:0] REV_MAX = 16'h7FFF;
  localparam logic [REV_W-1:0] REV_MIN = 16'h8000;

  localparam logic [PPR_W-1:0]  PPR_RESET  = 25'd1048576;
  localparam logic [BASE_W-1:0] BASE_RESET = 41'd1048576;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACK_MODE   = 3'd0,
    CFG_MODULO_OFF   = 3'd1,
    CFG_CHECK_ENABLE = 3'd2,
    CFG_MULTI_TURN   = 3'd3,
    CFG_PULSES       = 3'd4,
    CFG_MODULO_BASE  = 3'd5,
    CFG_START_TURN   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [REV_W-1:0] rev_count;
    logic [SINGLE_W-1:0]     single_turn;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    position_valid;
    logic signed [REV_W-1:0] turn_count;
    logic                    turn_wrapped;
    logic                    overspeed_alarm;
  } out_item_t;

endpackage

// ===== rtl/mtpt_if.sv =====
// Valid/ready channel interfaces for the input samples and the result items.
`timescale 1ns / 1ps
interface mtpt_in_if;
  logic               valid;
  logic               ready;
  mtpt_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mtpt_out_if;
  logic                valid;
  logic                ready;
  mtpt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/multiturn_encoder_position_tracker.sv =====
// Top level of the multi-turn encoder position tracker with overspeed check.
//
// One encoder sample (revolution count and single-turn value) is taken on in_i
// per transfer and exactly one result item leaves on out_o for each sample.
// The user must write registers through cfg_we_i/cfg_idx_i/cfg_data_i only
// while the block is idle; the block itself does not enforce this. Writing the
// start turn count also loads the turn overflow count.
// Warm-up samples, samples in overspeed checking mode and tracking samples all
// get their state update in the cycle of the input transfer. A tracking sample
// that yields a position then runs a shift-add multiply over the 25 multiplier
// bits (one multiplier bit a cycle), and when modulo reduction is on and the
// base is nonzero a sign fix step, a restoring remainder over the 64 dividend
// bits (one dividend bit a cycle) and a second sign fix step. These steps all
// go through the single shared 64-bit adder/subtractor. in_i.ready is high
// only while the sequencer is idle.
//
// The result sits in an output register, so the sequencer can return to idle
// and take the next sample while the receiver stalls; it waits before loading
// a new result only if the previous one has not been taken. Reset clears the
// tracking state, the sequencer and the output valid, and restores the
// register defaults.
`timescale 1ns / 1ps
module multiturn_encoder_position_tracker #(
  parameter int ACC_WIDTH = mtpt_pkg::ACC_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mtpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mtpt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mtpt_in_if.sink                         in_i,
  mtpt_out_if.source                      out_o
);

  localparam int REV_W    = mtpt_pkg::REV_W;
  localparam int WORD_W   = mtpt_pkg::WORD_W;
  localparam int PPR_W    = mtpt_pkg::PPR_W;
  localparam int BASE_W   = mtpt_pkg::BASE_W;
  localparam int POS_W    = mtpt_pkg::POS_W;
  localparam int PIDX_W   = $clog2(PPR_W);
  localparam int CNT_W    = $clog2(WORD_W);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_NEG1 = 6'b000100,
    S_DIV  = 6'b001000,
    S_NEG2 = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  // Configuration registers.
  logic              track_mode_q, modulo_off_q, check_en_q, multi_turn_q;
  logic [PPR_W-1:0]  ppr_q;
  logic [BASE_W-1:0] base_q;

  // Tracking and checking state.
  logic [1:0]                  trk_warm_q, trk_warm_d;
  logic [REV_W-1:0]            trk_last_q, trk_last_d;
  logic signed [ACC_WIDTH-1:0] acc_q, acc_d;
  logic [REV_W-1:0]            ovf_q, ovf_d;
  logic [1:0]                  chk_warm_q, chk_warm_d;
  logic [REV_W-1:0]            chk_last_q, chk_last_d;
  logic                        pos_valid_d, wrapped_d, alarm_d;

  // Sequencer and datapath.
  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [WORD_W-1:0]   prod_q, prod_d;
  logic [WORD_W-1:0]   mcand_q, mcand_d;
  logic [BASE_W-1:0]   rem_q, rem_d;
  logic                neg_q, neg_d;
  logic                pos_valid_q, wrapped_q, alarm_q;

  logic                out_valid_q, out_valid_d;
  mtpt_pkg::out_item_t out_data_q, out_data_d;

  // Shared adder/subtractor; on subtract the carry out means a >= b.
  logic [WORD_W-1:0] opa, opb;
  logic              op_sub;
  logic [WORD_W:0]   sum;
  logic [BASE_W:0]   rem_shift;

  logic in_fire;
  logic signed [REV_W:0] chk_diff;
  logic [REV_W-1:0]      rev;
  logic [REV_W-1:0]      rev_step;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign rev       = in_i.data.rev_count;
  assign rev_step  = rev - trk_last_q;
  assign chk_diff  = (REV_W+1)'(signed'(rev)) - (REV_W+1)'(signed'(chk_last_q));
  assign rem_shift = {rem_q, prod_q[WORD_W-1]};

  always_comb begin
    opa    = prod_q;
    opb    = '0;
    op_sub = 1'b0;
    case (state_q)
      S_MUL: begin
        opb = ppr_q[cnt_q[PIDX_W-1:0]] ? mcand_q : '0;
      end
      S_NEG1: begin
        opa    = '0;
        opb    = prod_q;
        op_sub = 1'b1;
      end
      S_DIV: begin
        opa    = WORD_W'(rem_shift);
        opb    = WORD_W'(base_q);
        op_sub = 1'b1;
      end
      S_NEG2: begin
        opa    = '0;
        opb    = WORD_W'(rem_q);
        op_sub = 1'b1;
      end
      default: begin
        opa = prod_q;
      end
    endcase
    sum = {1'b0, opa} + {1'b0, (op_sub ? ~opb : opb)} + (WORD_W+1)'(op_sub);
  end

  // Per-sample state update, done in the cycle of the input transfer.
  always_comb begin
    trk_warm_d  = trk_warm_q;
    trk_last_d  = trk_last_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    chk_warm_d  = chk_warm_q;
    chk_last_d  = chk_last_q;
    pos_valid_d = 1'b0;
    wrapped_d   = 1'b0;
    alarm_d     = 1'b0;

    if (!track_mode_q) begin
      trk_warm_d = '0;
    end else if (trk_warm_q < 2'(mtpt_pkg::WARMUP_DONE)) begin
      trk_warm_d = trk_warm_q + 2'd1;
      trk_last_d = rev;
      // The second warm-up sample seeds the accumulator from the turn count.
      if (trk_warm_d == 2'(mtpt_pkg::SEED_STEP)) begin
        acc_d = (ACC_WIDTH'(signed'(ovf_q)) <<< REV_W) + ACC_WIDTH'(signed'(rev));
      end
    end else begin
      if (rev == mtpt_pkg::REV_MIN && trk_last_q == mtpt_pkg::REV_MAX) begin
        ovf_d     = ovf_q + 16'd1;
        wrapped_d = 1'b1;
      end
      if (rev == mtpt_pkg::REV_MAX && trk_last_q == mtpt_pkg::REV_MIN) begin
        ovf_d     = ovf_q - 16'd1;
        wrapped_d = 1'b1;
      end
      acc_d       = acc_q + ACC_WIDTH'(signed'(rev_step));
      trk_last_d  = rev;
      pos_valid_d = 1'b1;
    end

    if (check_en_q && !track_mode_q) begin
      if (chk_warm_q < 2'(mtpt_pkg::WARMUP_DONE)) begin
        chk_last_d = rev;
        chk_warm_d = chk_warm_q + 2'd1;
      end else if (multi_turn_q) begin
        if (chk_diff > $signed((REV_W+1)'(mtpt_pkg::OVERSPEED_LIMIT)) ||
            chk_diff < -$signed((REV_W+1)'(mtpt_pkg::OVERSPEED_LIMIT))) begin
          alarm_d = 1'b1;
        end
        chk_last_d = rev;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    mcand_d     = mcand_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cnt_d   = '0;
          prod_d  = WORD_W'(in_i.data.single_turn);
          mcand_d = WORD_W'(acc_d);
          state_d = pos_valid_d ? S_MUL : S_OUT;
        end
      end
      S_MUL: begin
        prod_d  = sum[WORD_W-1:0];
        mcand_d = mcand_q << 1;
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(PPR_W - 1)) begin
          cnt_d   = '0;
          state_d = (modulo_off_q || base_q == '0) ? S_OUT : S_NEG1;
        end
      end
      S_NEG1: begin
        // Remainder is taken on the magnitude; its sign follows the dividend.
        neg_d   = prod_q[WORD_W-1];
        prod_d  = prod_q[WORD_W-1] ? sum[WORD_W-1:0] : prod_q;
        rem_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d  = sum[WORD_W] ? sum[BASE_W-1:0] : rem_shift[BASE_W-1:0];
        prod_d = prod_q << 1;
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WORD_W - 1)) begin
          state_d = S_NEG2;
        end
      end
      S_NEG2: begin
        prod_d  = neg_q ? sum[WORD_W-1:0] : WORD_W'(rem_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d                = 1'b1;
          out_data_d.position        = pos_valid_q ? prod_q[POS_W-1:0] : '0;
          out_data_d.position_valid  = pos_valid_q;
          out_data_d.turn_count      = ovf_q;
          out_data_d.turn_wrapped    = wrapped_q;
          out_data_d.overspeed_alarm = alarm_q;
          state_d                    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_mode_q <= 1'b0;
      modulo_off_q <= 1'b0;
      check_en_q   <= 1'b0;
      multi_turn_q <= 1'b0;
      ppr_q        <= mtpt_pkg::PPR_RESET;
      base_q       <= mtpt_pkg::BASE_RESET;
      trk_warm_q   <= '0;
      trk_last_q   <= '0;
      acc_q        <= '0;
      ovf_q        <= '0;
      chk_warm_q   <= '0;
      chk_last_q   <= '0;
      pos_valid_q  <= 1'b0;
      wrapped_q    <= 1'b0;
      alarm_q      <= 1'b0;
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        trk_warm_q  <= trk_warm_d;
        trk_last_q  <= trk_last_d;
        acc_q       <= acc_d;
        ovf_q       <= ovf_d;
        chk_warm_q  <= chk_warm_d;
        chk_last_q  <= chk_last_d;
        pos_valid_q <= pos_valid_d;
        wrapped_q   <= wrapped_d;
        alarm_q     <= alarm_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mtpt_pkg::CFG_TRACK_MODE:   track_mode_q <= cfg_data_i[0];
          mtpt_pkg::CFG_MODULO_OFF:   modulo_off_q <= cfg_data_i[0];
          mtpt_pkg::CFG_CHECK_ENABLE: check_en_q   <= cfg_data_i[0];
          mtpt_pkg::CFG_MULTI_TURN:   multi_turn_q <= cfg_data_i[0];
          mtpt_pkg::CFG_PULSES:       ppr_q        <= cfg_data_i[PPR_W-1:0];
          mtpt_pkg::CFG_MODULO_BASE:  base_q       <= cfg_data_i[BASE_W-1:0];
          mtpt_pkg::CFG_START_TURN:   ovf_q        <= cfg_data_i[REV_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    mcand_q    <= mcand_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

endmodule
